// ===== src/fuq_pkg.sv =====
// Shared types and constants for the byte queue with duplicate-refusing writes.
// No dependencies.
`default_nettype none
package fuq_pkg;

	localparam int DEPTH_DEF = 256;
	localparam int CAP_W     = 9;
	localparam int BYTE_W    = 8;
	localparam int FILL_W    = 9;
	localparam int VALS      = 256;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_DUP   = 2'd2;
	localparam logic [1:0] STAT_EMPTY = 2'd3;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	typedef struct packed {
		logic push;
		logic pop;
		logic flush;
	} ring_ctl_t;

	typedef struct packed {
		logic              we;
		logic [BYTE_W-1:0] addr;
	} cnt_wr_t;

endpackage
`default_nettype wire

// ===== src/fuq_ring.sv =====
// Entry memory of the circular queue with its head and tail pointers.
// Depends on fuq_pkg.
`default_nettype none
module fuq_ring import fuq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int HW    = 9
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ring_ctl_t         ctl,
	input  wire logic [HW-1:0]     cap,
	input  wire logic [BYTE_W-1:0] wdata,
	output logic      [BYTE_W-1:0] rdata
);

	localparam int CMPW = (AW + 1 > HW) ? AW + 1 : HW;

	logic [BYTE_W-1:0] mem_q [DEPTH];
	logic [BYTE_W-1:0] rdata_q;
	logic [AW-1:0]     head_q, tail_q, head_nx, tail_nx;
	logic [AW:0]       head_inc, tail_inc;

	assign head_inc = {1'b0, head_q} + 1'b1;
	assign tail_inc = {1'b0, tail_q} + 1'b1;
	assign head_nx  = (CMPW'(head_inc) >= CMPW'(cap)) ? '0 : head_inc[AW-1:0];
	assign tail_nx  = (CMPW'(tail_inc) >= CMPW'(cap)) ? '0 : tail_inc[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (ctl.flush) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (ctl.pop)
				head_q <= head_nx;
			if (ctl.push)
				tail_q <= tail_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push)
			mem_q[tail_q] <= wdata;
		rdata_q <= mem_q[head_q];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== src/fuq_occ.sv =====
// Per-byte-value occupancy counters used for the duplicate check, with clear sweep.
// Depends on fuq_pkg.
`default_nettype none
module fuq_occ import fuq_pkg::*; #(
	parameter int HW = 9
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              flush,
	input  wire logic [BYTE_W-1:0] rd_addr,
	output logic      [HW-1:0]     rd_data,
	input  wire cnt_wr_t           wr,
	input  wire logic [HW-1:0]     wr_data,
	output logic                   busy
);

	logic [HW-1:0]     mem_q [VALS];
	logic [HW-1:0]     rd_q;
	logic [BYTE_W-1:0] clr_idx_q;
	logic              busy_q;
	logic              we;
	logic [BYTE_W-1:0] waddr;
	logic [HW-1:0]     wdat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_idx_q <= '0;
		end else if (flush) begin
			busy_q    <= 1'b1;
			clr_idx_q <= '0;
		end else if (busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == BYTE_W'(VALS - 1))
				busy_q <= 1'b0;
		end
	end

	always_comb begin
		if (busy_q) begin
			we    = 1'b1;
			waddr = clr_idx_q;
			wdat  = '0;
		end else begin
			we    = wr.we;
			waddr = wr.addr;
			wdat  = wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdat;
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;
	assign busy    = busy_q;

endmodule
`default_nettype wire

// ===== src/byte_fifo_unique_write.sv =====
// An accepted transaction moves to the execute state; its result is registered there once the output
// register is free, later while m_tready is low. No new transaction is taken until the last is done:
// writes and failed reads pass idle and execute, successful reads also a decrement state that writes
// back the occupancy counter of the popped byte. Reset clears pointers and fill count and starts a
// clear sweep of all 256 occupancy counters; each nonzero capacity write empties the queue and repeats
// that clear. Input transactions are held off while the clear runs. Depends on fuq_pkg, fuq_ring, fuq_occ.
`default_nettype none
module byte_fifo_unique_write import fuq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [7:0] data_byte, [8] unique_required, rest 0
	input  wire logic [0:0]  s_tuser,   // [0] kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,   // [0] ok, [2:1] status, [10:3] read_byte,
	                                    // [19:11] fill_count, rest 0
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [8:0]  cfg_data   // capacity
);

	localparam int AW      = $clog2(DEPTH);
	localparam int MAXC    = (DEPTH < 511) ? DEPTH : 511;
	localparam int HW      = $clog2(MAXC + 1);
	localparam int CAP_RST = (DEPTH < 256) ? DEPTH : 256;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DEC  = 2'd2;

	logic [1:0]        state_q;
	logic              kind_s1, uniq_s1;
	logic [BYTE_W-1:0] data_s1;
	logic [HW-1:0]     cap_q, held_q, held_nx;
	logic [BYTE_W-1:0] pop_byte_q;
	logic              out_valid_q, ok_q;
	logic [1:0]        status_q;
	logic [BYTE_W-1:0] rbyte_q;
	logic [FILL_W-1:0] fill_q;

	logic              s_acc, cfg_set, out_free, exec_go;
	logic              full, empty, dup, do_push, do_pop;
	logic [1:0]        status_nx;
	ring_ctl_t         ring_ctl;
	logic [BYTE_W-1:0] ring_rdata;
	cnt_wr_t           occ_wr;
	logic [HW-1:0]     occ_wdata, occ_rdata;
	logic [BYTE_W-1:0] occ_raddr;
	logic              occ_busy;

	assign cfg_ready = 1'b1;
	assign cfg_set   = cfg_valid && (cfg_data != '0);
	assign s_tready  = (state_q == ST_IDLE) && !occ_busy;
	assign s_acc     = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign exec_go   = (state_q == ST_EXEC) && out_free;

	assign full    = held_q >= cap_q;
	assign empty   = held_q == '0;
	assign dup     = uniq_s1 && (occ_rdata != '0);
	assign do_push = exec_go && (kind_s1 == KIND_WRITE) && !full && !dup;
	assign do_pop  = exec_go && (kind_s1 == KIND_READ) && !empty;

	always_comb begin
		if (kind_s1 == KIND_READ)
			status_nx = empty ? STAT_EMPTY : STAT_DONE;
		else if (full)
			status_nx = STAT_FULL;
		else if (dup)
			status_nx = STAT_DUP;
		else
			status_nx = STAT_DONE;
	end

	always_comb begin
		held_nx = held_q;
		if (do_push)
			held_nx = held_q + 1'b1;
		else if (do_pop)
			held_nx = held_q - 1'b1;
	end

	// count reads follow the byte in flight; in the decrement cycle the popped byte is written back
	always_comb begin
		if (state_q == ST_EXEC)
			occ_raddr = (kind_s1 == KIND_READ) ? ring_rdata : data_s1;
		else
			occ_raddr = s_tdata[BYTE_W-1:0];
		if (state_q == ST_DEC) begin
			occ_wr.we   = 1'b1;
			occ_wr.addr = pop_byte_q;
			occ_wdata   = occ_rdata - 1'b1;
		end else begin
			occ_wr.we   = do_push;
			occ_wr.addr = data_s1;
			occ_wdata   = occ_rdata + 1'b1;
		end
	end

	assign ring_ctl.push  = do_push;
	assign ring_ctl.pop   = do_pop;
	assign ring_ctl.flush = cfg_set;

	fuq_ring #(.DEPTH(DEPTH), .AW(AW), .HW(HW)) u_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ring_ctl),
		.cap   (cap_q),
		.wdata (data_s1),
		.rdata (ring_rdata)
	);

	fuq_occ #(.HW(HW)) u_occ (
		.clk    (clk),
		.arst_n (arst_n),
		.flush  (cfg_set),
		.rd_addr(occ_raddr),
		.rd_data(occ_rdata),
		.wr     (occ_wr),
		.wr_data(occ_wdata),
		.busy   (occ_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= HW'(CAP_RST);
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_acc)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (exec_go)
						state_q <= do_pop ? ST_DEC : ST_IDLE;
				end
				ST_DEC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cfg_set) begin
				cap_q  <= (cfg_data > 9'(MAXC)) ? HW'(MAXC) : HW'(cfg_data);
				held_q <= '0;
			end else begin
				held_q <= held_nx;
			end

			if (exec_go)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			kind_s1 <= s_tuser[0];
			data_s1 <= s_tdata[BYTE_W-1:0];
			uniq_s1 <= s_tdata[8];
		end
		if (do_pop)
			pop_byte_q <= ring_rdata;
		if (exec_go) begin
			ok_q     <= do_push || do_pop;
			status_q <= status_nx;
			rbyte_q  <= do_pop ? ring_rdata : '0;
			fill_q   <= FILL_W'(held_nx);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, fill_q, rbyte_q, status_q, ok_q};

`ifndef SYNTHESIS
	a_held_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= cap_q)
		else $error("fill count above capacity");

	a_cfg_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_data != '0) |=> held_q == '0)
		else $error("capacity write did not empty queue");

	a_acc_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_EXEC)
		else $error("accepted transaction not executed");

	a_ok_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ok_q |-> status_q == STAT_DONE)
		else $error("ok result with failure status");

	a_no_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		occ_busy |-> !s_tready)
		else $error("input accepted during counter clear");
`endif

endmodule
`default_nettype wire

// ===== tb/byte_fifo_unique_write_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for byte_fifo_unique_write: a tracking queue predicts every
// result of write and read transactions across several capacity settings.
// Depends on fuq_pkg and the byte_fifo_unique_write RTL.
module byte_fifo_unique_write_test;
	import fuq_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_AT    = 450;
	localparam int HOLD_LEN   = 80;
	localparam int TAIL_WAIT  = 10;

	typedef struct packed {
		logic [3:0]        pad;
		logic [FILL_W-1:0] fill;
		logic [BYTE_W-1:0] rbyte;
		logic [1:0]        status;
		logic              ok;
	} result_t;

	class queue_scoreboard;
		logic [BYTE_W-1:0] held_bytes [0:DEPTH_DEF-1];
		int unsigned rd_ptr, wr_ptr, n_held, cap;
		result_t pending_results [$];
		int errors;

		function new();
			cap = DEPTH_DEF;
			rd_ptr = 0;
			wr_ptr = 0;
			n_held = 0;
			errors = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] v);
			if (v != 0) begin
				cap = (v > DEPTH_DEF) ? DEPTH_DEF : v;
				rd_ptr = 0;
				wr_ptr = 0;
				n_held = 0;
			end
		endfunction

		function int unsigned advance(int unsigned idx);
			return (idx + 1 >= cap) ? 0 : idx + 1;
		endfunction

		function bit holds(logic [BYTE_W-1:0] b);
			int unsigned idx;
			idx = rd_ptr;
			for (int k = 0; k < n_held; k++) begin
				if (held_bytes[idx] == b)
					return 1'b1;
				idx = advance(idx);
			end
			return 1'b0;
		endfunction

		function void note_op(logic kind, logic [BYTE_W-1:0] b, logic uniq);
			result_t r;
			r = '0;
			if (kind == KIND_WRITE) begin
				if (n_held >= cap) begin
					r.status = STAT_FULL;
				end else if (uniq && holds(b)) begin
					r.status = STAT_DUP;
				end else begin
					held_bytes[wr_ptr] = b;
					wr_ptr = advance(wr_ptr);
					n_held++;
					r.ok = 1'b1;
					r.status = STAT_DONE;
				end
			end else begin
				if (n_held == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.rbyte = held_bytes[rd_ptr];
					rd_ptr = advance(rd_ptr);
					n_held--;
					r.ok = 1'b1;
					r.status = STAT_DONE;
				end
			end
			r.fill = n_held[FILL_W-1:0];
			pending_results.push_back(r);
		endfunction

		function void cmp_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(logic [23:0] data);
			result_t got, want;
			got = data;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got 0x%06h", $time, data);
			end else begin
				want = pending_results.pop_front();
				cmp_field("ok", want.ok, got.ok);
				cmp_field("status", want.status, got.status);
				cmp_field("read_byte", want.rbyte, got.rbyte);
				cmp_field("fill_count", want.fill, got.fill);
				cmp_field("padding", want.pad, got.pad);
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [7:0] data_byte, [8] unique_required, rest 0
	logic [0:0]  s_tuser = '0;   // [0] kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // [0] ok, [2:1] status, [10:3] read_byte, [19:11] fill_count
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [8:0]  cfg_data = '0;

	queue_scoreboard sb = new();
	bit idle_on = 1'b1;
	int results_seen = 0;
	int idle_cycles = 0;

	byte_fifo_unique_write i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result sink with random stalls and one long hold-off
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = idle_on ? $urandom_range(0, 4) : 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			sb.check_result(m_tdata);
			results_seen++;
			if (results_seen == HOLD_AT) begin
				m_tready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
			end
		end
	end

	task automatic send_op(input logic kind, input logic [BYTE_W-1:0] b, input logic uniq);
		int gap;
		gap = idle_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, uniq, b};
		s_tuser  <= kind;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_op(kind, b, uniq);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.set_capacity(v);
	endtask

	task automatic drain();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic random_ops(input int n, input int wr_pct, input int uq_pct,
			input int pool, input int pause_at);
		logic kind;
		for (int i = 0; i < n; i++) begin
			if (i == pause_at) begin
				s_tvalid <= 1'b0;
				drain();
			end
			kind = ($urandom_range(0, 99) < wr_pct) ? KIND_WRITE : KIND_READ;
			send_op(kind, BYTE_W'($urandom_range(0, pool)), $urandom_range(0, 99) < uq_pct);
		end
		s_tvalid <= 1'b0;
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset capacity: empty read, duplicate refusal, plain duplicate allowed
		idle_on = 1'b1;
		send_op(KIND_READ,  8'h00, 1'b0);
		send_op(KIND_WRITE, 8'h00, 1'b0);
		send_op(KIND_WRITE, 8'hFF, 1'b1);
		send_op(KIND_WRITE, 8'hFF, 1'b1);
		send_op(KIND_WRITE, 8'h00, 1'b0);
		send_op(KIND_READ,  8'hFF, 1'b1);
		send_op(KIND_READ,  8'h00, 1'b0);
		send_op(KIND_READ,  8'h55, 1'b0);
		send_op(KIND_READ,  8'hAA, 1'b1);
		random_ops(300, 97, 10, 255, -1);

		// single entry: full reported ahead of the duplicate check
		idle_on = 1'b0;
		write_capacity(9'd1);
		send_op(KIND_WRITE, 8'h5A, 1'b0);
		send_op(KIND_WRITE, 8'h5A, 1'b1);
		send_op(KIND_WRITE, 8'hA5, 1'b0);
		send_op(KIND_READ,  8'h00, 1'b0);
		send_op(KIND_READ,  8'h00, 1'b0);
		random_ops(60, 50, 50, 255, -1);

		// zero capacity write leaves register and contents alone
		idle_on = 1'b1;
		write_capacity(9'd0);
		random_ops(40, 60, 50, 3, -1);

		idle_on = 1'b1;
		write_capacity(9'd300);
		random_ops(120, 55, 60, 15, 60);

		idle_on = 1'b0;
		write_capacity(9'd3);
		random_ops(100, 55, 50, 3, -1);

		idle_on = 1'b1;
		write_capacity(9'd511);
		random_ops(60, 50, 30, 255, -1);

		idle_on = 1'b1;
		write_capacity(9'd2);
		random_ops(60, 50, 50, 1, -1);

		for (int p = 0; p < 3; p++) begin
			idle_on = (p != 1);
			write_capacity(CAP_W'($urandom_range(1, DEPTH_DEF)));
			random_ops(50, 60, 40, 31, -1);
		end

		repeat (TAIL_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
